// File: rtl/core/sfrb_pkg.sv
// ----------------------------------------------------------------------------
// sfrb_pkg
// shared widths, operation codes, control structs and the reciprocal table
// for the scan frame ring buffer
// ----------------------------------------------------------------------------
`default_nettype none

package sfrb_pkg;

	localparam int OP_W     = 2;
	localparam int SAMPLE_W = 16;
	localparam int ANGLE_W  = 11;
	localparam int DIST_W   = 16;
	localparam int RES_W    = 4;

	localparam int FRAMES_DEF       = 8;
	localparam int RANGE_TENTHS_DEF = 1800;
	localparam int SAMPLE_BITS_DEF  = 16;

	localparam logic [RES_W-1:0] RES_RESET = 4'd10;
	localparam logic [RES_W-1:0] RES_MIN   = 4'd1;
	localparam logic [RES_W-1:0] RES_MAX   = 4'd10;

	// query divide: quotient of (angle + (res-1)/2) by res through a reciprocal
	localparam int RECIP_SHIFT = 16;
	localparam int RECIP_W     = RECIP_SHIFT + 1;
	localparam int RECIP_ONE   = 1 << RECIP_SHIFT;
	localparam int QW          = ANGLE_W + 1;

	typedef logic [OP_W-1:0] op_t;

	localparam op_t OP_WRITE = 2'd0;
	localparam op_t OP_POP   = 2'd1;
	localparam op_t OP_CLEAR = 2'd2;
	localparam op_t OP_QUERY = 2'd3;

	typedef struct packed {
		logic latch;
		logic exec;
		logic qdiv;
		logic addr;
		logic access;
		logic load_out;
	} sfrb_cmd_t;

	typedef struct packed {
		op_t  op;
		logic no_data;
	} sfrb_status_t;

	function automatic logic [RECIP_W-1:0] recip(input logic [RES_W-1:0] r);
		logic [RECIP_W-1:0] v;
		unique case (r)
			4'd1:    v = RECIP_W'(RECIP_ONE / 1);
			4'd2:    v = RECIP_W'(RECIP_ONE / 2);
			4'd3:    v = RECIP_W'(RECIP_ONE / 3);
			4'd4:    v = RECIP_W'(RECIP_ONE / 4);
			4'd5:    v = RECIP_W'(RECIP_ONE / 5);
			4'd6:    v = RECIP_W'(RECIP_ONE / 6);
			4'd7:    v = RECIP_W'(RECIP_ONE / 7);
			4'd8:    v = RECIP_W'(RECIP_ONE / 8);
			4'd9:    v = RECIP_W'(RECIP_ONE / 9);
			default: v = RECIP_W'(RECIP_ONE / 10);
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

// File: rtl/core/sfrb_if.sv
// ----------------------------------------------------------------------------
// sfrb_if
// valid/ready channels of the scan frame ring buffer: input items, results
// and the configuration write
// ----------------------------------------------------------------------------
`default_nettype none

interface sfrb_in_if import sfrb_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [OP_W-1:0]     op;
	logic [SAMPLE_W-1:0] sample;
	logic                sample_last;
	logic [ANGLE_W-1:0]  angle_tenths;

	modport source(output valid, op, sample, sample_last, angle_tenths, input ready);
	modport sink(input valid, op, sample, sample_last, angle_tenths, output ready);
endinterface

interface sfrb_out_if import sfrb_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [DIST_W-1:0] distance;
	logic              frame_last;
	logic              empty_res;

	modport source(output valid, distance, frame_last, empty_res, input ready);
	modport sink(input valid, distance, frame_last, empty_res, output ready);
endinterface

interface sfrb_cfg_if import sfrb_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [RES_W-1:0] resolution_tenths;

	modport source(output valid, resolution_tenths, input ready);
	modport sink(input valid, resolution_tenths, output ready);
endinterface

`default_nettype wire

// File: rtl/core/sfrb_ctrl.sv
// ----------------------------------------------------------------------------
// sfrb_ctrl
// sequencer: steps each accepted transaction through execute and, per op,
// divide, address, memory access, result hand-off; owns the result valid
// ----------------------------------------------------------------------------
`default_nettype none

module sfrb_ctrl import sfrb_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	output logic         out_valid,
	input  logic         out_ready,
	input  sfrb_status_t status,
	output sfrb_cmd_t    cmd
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_EXEC   = 3'd1;
	localparam logic [2:0] ST_QDIV   = 3'd2;
	localparam logic [2:0] ST_ADDR   = 3'd3;
	localparam logic [2:0] ST_ACCESS = 3'd4;
	localparam logic [2:0] ST_DONE   = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;
	logic       out_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		cmd          = '0;
		cmd.latch    = in_valid && in_ready;
		cmd.exec     = (state_q == ST_EXEC);
		cmd.qdiv     = (state_q == ST_QDIV);
		cmd.addr     = (state_q == ST_ADDR);
		cmd.access   = (state_q == ST_ACCESS);
		cmd.load_out = (state_q == ST_DONE) && out_free;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				unique case (status.op)
					OP_WRITE: state_d = ST_ADDR;
					OP_CLEAR: state_d = ST_IDLE;
					OP_POP:   state_d = status.no_data ? ST_DONE : ST_ADDR;
					default:  state_d = status.no_data ? ST_DONE : ST_QDIV;
				endcase
			end
			ST_QDIV:   state_d = ST_ADDR;
			ST_ADDR:   state_d = ST_ACCESS;
			ST_ACCESS: state_d = (status.op == OP_WRITE) ? ST_IDLE : ST_DONE;
			ST_DONE: begin
				if (out_free) state_d = ST_IDLE;
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/sfrb_dp.sv
// ----------------------------------------------------------------------------
// sfrb_dp
// datapath: ring pointers, frame store, per-slot fill counts, query divide
// and the result register
// ----------------------------------------------------------------------------
`default_nettype none

module sfrb_dp import sfrb_pkg::*; #(
	parameter int FRAMES       = FRAMES_DEF,
	parameter int RANGE_TENTHS = RANGE_TENTHS_DEF,
	parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  sfrb_cmd_t           cmd,
	output sfrb_status_t        status,
	input  logic [OP_W-1:0]     in_op,
	input  logic [SAMPLE_W-1:0] in_sample,
	input  logic                in_sample_last,
	input  logic [ANGLE_W-1:0]  in_angle_tenths,
	input  logic                cfg_we,
	input  logic [RES_W-1:0]    cfg_data,
	output logic [DIST_W-1:0]   distance,
	output logic                frame_last,
	output logic                empty_res
);

	localparam int STRIDE = RANGE_TENTHS + 1;
	localparam int DEPTH  = FRAMES * STRIDE;
	localparam int SW     = $clog2(FRAMES);
	localparam int HW     = $clog2(FRAMES + 1);
	localparam int BW     = $clog2(STRIDE + 1);
	localparam int AW     = $clog2(DEPTH);
	localparam int CW     = (BW > QW) ? BW : QW;
	localparam int PRW    = QW + RECIP_W;
	localparam int PW     = QW + RES_W;

	// ring and cursor state
	logic [RES_W-1:0] res_q;
	logic [SW-1:0]    oldest_q;
	logic [SW-1:0]    newest_q;
	logic [HW-1:0]    held_q;
	logic [BW-1:0]    write_bin_q;
	logic [BW-1:0]    read_bin_q;
	logic             newest_valid_q;

	// latched transaction
	op_t                 op_q;
	logic [SAMPLE_W-1:0] sample_q;
	logic                last_q;
	logic [ANGLE_W-1:0]  angle_q;

	// access pipeline
	logic [SW-1:0]          slot_q;
	logic [BW-1:0]          idx_q;
	logic                   fin_q;
	logic                   wr_en_q;
	logic                   wr_zero_q;
	logic                   empty_q;
	logic [QW-1:0]          m_q;
	logic [PRW-1:0]         prod_q;
	logic [AW-1:0]          addr_q;
	logic [SAMPLE_BITS-1:0] rdata_q;
	logic [BW-1:0]          fill_rd_q;

	logic [SAMPLE_BITS-1:0] frame_mem [DEPTH];
	logic [BW-1:0]          fill_mem  [FRAMES];

	logic [RES_W-1:0]       res_eff;
	logic [BW-1:0]          nb;
	logic [BW-1:0]          nb_m1;
	logic [SW-1:0]          oldest_next;
	logic [HW:0]            slot_sum;
	logic [SW-1:0]          target;
	logic                   drop;
	logic [BW-1:0]          wb_next;
	logic [BW-1:0]          fill_val;
	logic [BW-1:0]          fill_cur;
	logic                   z_adv;
	logic [BW-1:0]          pop_idx;
	logic                   pop_fin;
	logic [ANGLE_W+1:0]     q_num;
	logic [QW-1:0]          q_m;
	logic [QW-1:0]          q0;
	logic [PW-1:0]          q0_r;
	logic [PW-1:0]          q_rem;
	logic [QW-1:0]          q_k;
	logic [CW-1:0]          q_kc;
	logic [BW-1:0]          q_idx;
	logic [31:0]            sample_wide;
	logic [31:0]            rdata_wide;
	logic [SAMPLE_BITS-1:0] rd_val;

	always_comb begin
		res_eff = res_q;
		if (res_q < RES_MIN) res_eff = RES_MIN;
		if (res_q > RES_MAX) res_eff = RES_MAX;
	end

	always_comb begin
		unique case (res_eff)
			4'd1:    nb = BW'(RANGE_TENTHS / 1 + 1);
			4'd2:    nb = BW'(RANGE_TENTHS / 2 + 1);
			4'd3:    nb = BW'(RANGE_TENTHS / 3 + 1);
			4'd4:    nb = BW'(RANGE_TENTHS / 4 + 1);
			4'd5:    nb = BW'(RANGE_TENTHS / 5 + 1);
			4'd6:    nb = BW'(RANGE_TENTHS / 6 + 1);
			4'd7:    nb = BW'(RANGE_TENTHS / 7 + 1);
			4'd8:    nb = BW'(RANGE_TENTHS / 8 + 1);
			4'd9:    nb = BW'(RANGE_TENTHS / 9 + 1);
			default: nb = BW'(RANGE_TENTHS / 10 + 1);
		endcase
	end

	assign nb_m1       = nb - BW'(1);
	assign oldest_next = (oldest_q == SW'(FRAMES - 1)) ? '0 : oldest_q + SW'(1);

	// slot being written sits just past the held frames; a drop moves both ends
	assign slot_sum = (HW+1)'(oldest_q) + (HW+1)'(held_q);
	assign target   = (slot_sum >= (HW+1)'(FRAMES)) ? SW'(slot_sum - (HW+1)'(FRAMES))
	                                                : SW'(slot_sum);
	assign drop     = (write_bin_q == '0) && (held_q == HW'(FRAMES));
	assign wb_next  = (write_bin_q < BW'(STRIDE)) ? write_bin_q + BW'(1) : write_bin_q;
	assign fill_val = (wb_next < nb) ? wb_next : nb;

	// a bin at or past the slot's fill count moves the count up; a skipped one
	// is stored as zero so a later, wider scan still reads padding there
	assign fill_cur = fill_mem[target];
	assign z_adv    = (write_bin_q >= fill_cur) && (write_bin_q < BW'(STRIDE));

	assign pop_idx = (read_bin_q < nb_m1) ? read_bin_q : nb_m1;
	assign pop_fin = (pop_idx == nb_m1);

	// round to nearest bin, ties low: floor((angle + (res-1)/2) / res)
	assign q_num = (ANGLE_W+2)'({angle_q, 1'b0}) + (ANGLE_W+2)'(res_eff)
	             - (ANGLE_W+2)'(1);

	assign q_m   = q_num[ANGLE_W+1:1];
	assign q0    = prod_q[RECIP_SHIFT +: QW];
	assign q0_r  = PW'(q0) * PW'(res_eff);
	assign q_rem = PW'(m_q) - q0_r;
	assign q_k   = (q_rem >= PW'(res_eff)) ? q0 + QW'(1) : q0;
	assign q_kc  = (CW'(q_k) > CW'(nb_m1)) ? CW'(nb_m1) : CW'(q_k);
	assign q_idx = BW'(q_kc);

	assign sample_wide = 32'(sample_q);
	assign rdata_wide  = 32'(rd_val);
	assign rd_val      = (idx_q < fill_rd_q) ? rdata_q : '0;

	always_comb begin
		status.op      = op_q;
		status.no_data = (op_q == OP_POP) ? (held_q == '0) : !newest_valid_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q          <= RES_RESET;
			oldest_q       <= '0;
			newest_q       <= '0;
			held_q         <= '0;
			write_bin_q    <= '0;
			read_bin_q     <= '0;
			newest_valid_q <= 1'b0;
		end else begin
			if (cfg_we) res_q <= cfg_data;
			if (cmd.exec) begin
				unique case (op_q)
					OP_WRITE: begin
						if (drop) begin
							oldest_q   <= oldest_next;
							read_bin_q <= '0;
						end
						if (last_q) begin
							newest_q       <= target;
							newest_valid_q <= 1'b1;
							held_q         <= drop ? held_q : held_q + HW'(1);
							write_bin_q    <= '0;
						end else begin
							held_q      <= drop ? held_q - HW'(1) : held_q;
							write_bin_q <= wb_next;
						end
					end
					OP_CLEAR: begin
						oldest_q       <= '0;
						newest_q       <= '0;
						held_q         <= '0;
						write_bin_q    <= '0;
						read_bin_q     <= '0;
						newest_valid_q <= 1'b0;
					end
					OP_POP: begin
						if (held_q != '0) begin
							if (pop_fin) begin
								oldest_q   <= oldest_next;
								held_q     <= held_q - HW'(1);
								read_bin_q <= '0;
								if (held_q == HW'(1)) newest_valid_q <= 1'b0;
							end else begin
								read_bin_q <= pop_idx + BW'(1);
							end
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			op_q     <= in_op;
			sample_q <= in_sample;
			last_q   <= in_sample_last;
			angle_q  <= in_angle_tenths;
		end
		if (cmd.exec) begin
			empty_q   <= status.no_data;
			fin_q     <= 1'b0;
			m_q       <= q_m;
			prod_q    <= PRW'(q_m) * PRW'(recip(res_eff));
			wr_en_q   <= (write_bin_q < nb) || z_adv;
			wr_zero_q <= !(write_bin_q < nb);
			unique case (op_q)
				OP_WRITE: begin
					slot_q <= target;
					idx_q  <= write_bin_q;
				end
				OP_POP: begin
					slot_q <= oldest_q;
					idx_q  <= pop_idx;
					fin_q  <= pop_fin;
				end
				default: begin
					slot_q <= newest_q;
					idx_q  <= '0;
				end
			endcase
		end
		if (cmd.qdiv) idx_q <= q_idx;
		if (cmd.addr) addr_q <= AW'(slot_q) * AW'(STRIDE) + AW'(idx_q);
		if (cmd.load_out) begin
			distance   <= empty_q ? '0 : rdata_wide[DIST_W-1:0];
			frame_last <= !empty_q && fin_q;
			empty_res  <= empty_q;
		end
	end

	// frame store: one write or one read per access cycle
	always_ff @(posedge clk) begin
		if (cmd.access) begin
			if (op_q == OP_WRITE) begin
				if (wr_en_q) begin
					frame_mem[addr_q] <= wr_zero_q ? '0 : sample_wide[SAMPLE_BITS-1:0];
				end
			end else begin
				rdata_q <= frame_mem[addr_q];
			end
		end
	end

	// bins at or past the fill count read as zero padding
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < FRAMES; i++) fill_mem[i] <= '0;
		end else if (cmd.exec && (op_q == OP_WRITE)) begin
			if (last_q) begin
				fill_mem[target] <= fill_val;
			end else if (z_adv) begin
				fill_mem[target] <= wb_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.access) fill_rd_q <= fill_mem[slot_q];
	end

endmodule

`default_nettype wire

// File: rtl/core/scan_frame_ring_buffer_unit.sv
// ----------------------------------------------------------------------------
// scan_frame_ring_buffer_unit
// ring of lidar scans with sample write, oldest-bin pop, clear and
// nearest-bin distance query from the newest scan
// ----------------------------------------------------------------------------
// cycles through steps after acceptance: write runs execute, address, access;
// clear runs execute alone; pop adds a result hand-off; query also divides before
// address; empty pop or query skips to hand-off; result valid is set at hand-off
// an output register lets the next transaction in while a result waits
// reset clears the ring pointers, counters and per-slot fill counts at once;
// the frame store is not swept, bins at or past a slot's fill count read zero
`default_nettype none

module scan_frame_ring_buffer_unit import sfrb_pkg::*; #(
	parameter int FRAMES       = FRAMES_DEF,
	parameter int RANGE_TENTHS = RANGE_TENTHS_DEF,
	parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	sfrb_in_if.sink      item,
	sfrb_out_if.source   result,
	sfrb_cfg_if.sink     cfg
);

	sfrb_cmd_t    cmd;
	sfrb_status_t status;
	logic         in_ready;
	logic         out_valid;

	assign item.ready   = in_ready;
	assign result.valid = out_valid;
	assign cfg.ready    = 1'b1;

	sfrb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item.valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (result.ready),
		.status    (status),
		.cmd       (cmd)
	);

	sfrb_dp #(
		.FRAMES       (FRAMES),
		.RANGE_TENTHS (RANGE_TENTHS),
		.SAMPLE_BITS  (SAMPLE_BITS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.status          (status),
		.in_op           (item.op),
		.in_sample       (item.sample),
		.in_sample_last  (item.sample_last),
		.in_angle_tenths (item.angle_tenths),
		.cfg_we          (cfg.valid),
		.cfg_data        (cfg.resolution_tenths),
		.distance        (result.distance),
		.frame_last      (result.frame_last),
		.empty_res       (result.empty_res)
	);

endmodule

`default_nettype wire
